@@ hw/rtl/pat_pkg.sv @@
// Shared types and constants of the paged address translator.
package pat_pkg;

	localparam int LA_W    = 20;
	localparam int PS_W    = 16;
	localparam int PA_W    = 25;
	localparam int BASE_W  = 24;
	localparam int PIDX_W  = 4;
	localparam int FIDX_W  = 5;
	localparam int PCNT_W  = 5;
	localparam int FCNT_W  = 6;
	localparam int STAT_W  = 3;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;
	localparam int DCNT_W  = $clog2(LA_W);

	localparam logic [PS_W-1:0]   PAGE_SIZE_RST   = PS_W'(1024);
	localparam logic [PCNT_W-1:0] PAGE_COUNT_RST  = PCNT_W'(16);
	localparam logic [FCNT_W-1:0] FRAME_COUNT_RST = FCNT_W'(32);
	localparam logic [BASE_W-1:0] BASE_RST        = '0;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_ABSENT      = 3'd1,
		STAT_PAGE_RANGE  = 3'd2,
		STAT_FRAME_RANGE = 3'd3,
		STAT_MAPPED      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_PAGE_SIZE    = 2'd0,
		REG_PAGE_COUNT   = 2'd1,
		REG_FRAME_COUNT  = 2'd2,
		REG_BASE_ADDRESS = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_READ,
		S_LOOK,
		S_MUL,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ hw/rtl/pat_div.sv @@
// Radix-2 restoring divider that produces one quotient bit per cycle.
module pat_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pat_pkg::LA_W-1:0]  dividend,
	input  logic [pat_pkg::PS_W-1:0]  divisor,
	output logic [pat_pkg::LA_W-1:0]  quotient,
	output logic [pat_pkg::PS_W-1:0]  remainder,
	output pat_pkg::div_stat_t        stat
);

	logic [pat_pkg::LA_W-1:0]   d_q;
	logic [pat_pkg::PS_W-1:0]   r_q;
	logic [pat_pkg::DCNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [pat_pkg::PS_W:0]     shifted;
	logic [pat_pkg::PS_W:0]     trial;

	// The partial remainder stays below the divisor, so the shifted value fits in 17 bits.
	assign shifted = {r_q, d_q[pat_pkg::LA_W-1]};
	assign trial   = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= pat_pkg::DCNT_W'(pat_pkg::LA_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			if (!trial[pat_pkg::PS_W]) begin
				r_q <= trial[pat_pkg::PS_W-1:0];
				d_q <= {d_q[pat_pkg::LA_W-2:0], 1'b1};
			end else begin
				r_q <= shifted[pat_pkg::PS_W-1:0];
				d_q <= {d_q[pat_pkg::LA_W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = d_q;
	assign remainder = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ hw/rtl/paged_address_translator.sv @@
// Top level of the paged address translator: registers, page table and sequencer.
//
// Input channel (in_valid/in_ready) takes one word per item: a map item writes a frame
// number into the page table, a translate item turns logical_address into a physical one.
// Output channel (out_valid/out_ready) returns one word per item: physical_address and
// status. The APB port holds page_size, page_count, frame_count and base_address.
// Items are worked one at a time. A map item goes from acceptance through the table read
// and the checks, which write the entry on success, to the output register. A translate
// item first runs the serial divider, one quotient bit per cycle over the 20-bit address,
// to split logical_address into page and offset; then come the table read and the checks,
// and only if they pass, the shift-add multiplier for frame * page_size, which stops once
// the remaining frame bits are zero. The next item can be accepted in the cycle after
// the word is loaded.
// After reset the block clears every entry of the page table, during which in_ready is
// low; register writes are taken throughout.
// A finished word sits in the output register until taken, and the next item may be
// accepted meanwhile; a stalled receiver holds back only the item after that one.
module paged_address_translator #(
	parameter int MAX_PAGES  = 16,
	parameter int MAX_FRAMES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pat_pkg::APB_AW-1:0]  paddr,
	input  logic [pat_pkg::APB_DW-1:0]  pwdata,
	output logic [pat_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic [pat_pkg::PIDX_W-1:0]  page_index,
	input  logic [pat_pkg::FIDX_W-1:0]  frame_index,
	input  logic [pat_pkg::LA_W-1:0]    logical_address,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pat_pkg::PA_W-1:0]    physical_address,
	output logic [pat_pkg::STAT_W-1:0]  status
);

	localparam int TIW  = $clog2(MAX_PAGES);
	localparam int FW   = $clog2(MAX_FRAMES);
	localparam int EW   = FW + 1;
	localparam int PCW  = $clog2(MAX_PAGES + 1);
	localparam int FCW  = $clog2(MAX_FRAMES + 1);
	localparam int PLW  = (PCW > pat_pkg::PCNT_W) ? PCW : pat_pkg::PCNT_W;
	localparam int FLW  = (FCW > pat_pkg::FCNT_W) ? FCW : pat_pkg::FCNT_W;

	// Configuration registers.
	logic [pat_pkg::PS_W-1:0]   page_size_q;
	logic [pat_pkg::PCNT_W-1:0] page_count_q;
	logic [pat_pkg::FCNT_W-1:0] frame_count_q;
	logic [pat_pkg::BASE_W-1:0] base_address_q;
	logic                       cfg_write;
	pat_pkg::reg_idx_t          cfg_idx;

	// Sequencer and item state.
	pat_pkg::state_t            state_q;
	pat_pkg::state_t            state_next;
	logic [TIW-1:0]             clr_q;
	logic                       kind_q;
	logic [pat_pkg::PIDX_W-1:0] pidx_q;
	logic [pat_pkg::FIDX_W-1:0] fidx_q;
	logic [TIW-1:0]             addr_q;
	pat_pkg::status_t           res_status_q;
	logic [pat_pkg::PA_W-1:0]   acc_q;
	logic [pat_pkg::PA_W-1:0]   mcand_q;
	logic [FW-1:0]              mplier_q;

	// Page table.
	logic [EW-1:0]              table_mem [MAX_PAGES];
	logic [EW-1:0]              rd_q;
	logic                       tbl_we;
	logic [TIW-1:0]             tbl_waddr;
	logic [EW-1:0]              tbl_wdata;

	// Output register.
	logic                       out_valid_q;
	logic [pat_pkg::PA_W-1:0]   physical_address_q;
	pat_pkg::status_t           status_q;
	logic                       out_load;

	// Divider.
	logic                       div_start;
	logic [pat_pkg::LA_W-1:0]   quot;
	logic [pat_pkg::PS_W-1:0]   rem;
	pat_pkg::div_stat_t         div_st;

	logic [pat_pkg::PS_W-1:0]   ps_eff;
	logic [PLW-1:0]             eff_pages;
	logic [FLW-1:0]             eff_frames;
	pat_pkg::status_t           look_status;

	assign ps_eff     = (page_size_q == '0) ? pat_pkg::PS_W'(1) : page_size_q;
	assign eff_pages  = (PLW'(page_count_q) > PLW'(MAX_PAGES)) ? PLW'(MAX_PAGES)
		: PLW'(page_count_q);
	assign eff_frames = (FLW'(frame_count_q) > FLW'(MAX_FRAMES)) ? FLW'(MAX_FRAMES)
		: FLW'(frame_count_q);

	// APB register file.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_idx   = pat_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q    <= pat_pkg::PAGE_SIZE_RST;
			page_count_q   <= pat_pkg::PAGE_COUNT_RST;
			frame_count_q  <= pat_pkg::FRAME_COUNT_RST;
			base_address_q <= pat_pkg::BASE_RST;
		end else if (cfg_write) begin
			case (cfg_idx)
				pat_pkg::REG_PAGE_SIZE:    page_size_q    <= pwdata[pat_pkg::PS_W-1:0];
				pat_pkg::REG_PAGE_COUNT:   page_count_q   <= pwdata[pat_pkg::PCNT_W-1:0];
				pat_pkg::REG_FRAME_COUNT:  frame_count_q  <= pwdata[pat_pkg::FCNT_W-1:0];
				pat_pkg::REG_BASE_ADDRESS: base_address_q <= pwdata[pat_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			pat_pkg::REG_PAGE_SIZE:    prdata = pat_pkg::APB_DW'(page_size_q);
			pat_pkg::REG_PAGE_COUNT:   prdata = pat_pkg::APB_DW'(page_count_q);
			pat_pkg::REG_FRAME_COUNT:  prdata = pat_pkg::APB_DW'(frame_count_q);
			pat_pkg::REG_BASE_ADDRESS: prdata = pat_pkg::APB_DW'(base_address_q);
			default:                   prdata = '0;
		endcase
	end

	pat_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (logical_address),
		.divisor   (ps_eff),
		.quotient  (quot),
		.remainder (rem),
		.stat      (div_st)
	);

	// Checks made once the table entry has been read.
	always_comb begin
		if (!kind_q) begin
			if (PLW'(pidx_q) >= eff_pages) begin
				look_status = pat_pkg::STAT_PAGE_RANGE;
			end else if (FLW'(fidx_q) >= eff_frames) begin
				look_status = pat_pkg::STAT_FRAME_RANGE;
			end else if (rd_q[EW-1]) begin
				look_status = pat_pkg::STAT_MAPPED;
			end else begin
				look_status = pat_pkg::STAT_OK;
			end
		end else begin
			if (quot >= pat_pkg::LA_W'(eff_pages)) begin
				look_status = pat_pkg::STAT_PAGE_RANGE;
			end else if (!rd_q[EW-1]) begin
				look_status = pat_pkg::STAT_ABSENT;
			end else if (FLW'(rd_q[FW-1:0]) >= eff_frames) begin
				look_status = pat_pkg::STAT_FRAME_RANGE;
			end else begin
				look_status = pat_pkg::STAT_OK;
			end
		end
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			pat_pkg::S_CLEAR: begin
				if (clr_q == TIW'(MAX_PAGES - 1)) state_next = pat_pkg::S_IDLE;
			end
			pat_pkg::S_IDLE: begin
				if (in_valid) state_next = kind ? pat_pkg::S_DIV : pat_pkg::S_READ;
			end
			pat_pkg::S_DIV: begin
				if (div_st.done) state_next = pat_pkg::S_READ;
			end
			pat_pkg::S_READ: begin
				state_next = pat_pkg::S_LOOK;
			end
			pat_pkg::S_LOOK: begin
				if (kind_q && look_status == pat_pkg::STAT_OK) begin
					state_next = pat_pkg::S_MUL;
				end else begin
					state_next = pat_pkg::S_DONE;
				end
			end
			pat_pkg::S_MUL: begin
				if (mplier_q == '0) state_next = pat_pkg::S_DONE;
			end
			pat_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) state_next = pat_pkg::S_IDLE;
			end
			default: state_next = pat_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready  = (state_q == pat_pkg::S_IDLE);
		div_start = (state_q == pat_pkg::S_IDLE) && in_valid && kind;
		out_load  = (state_q == pat_pkg::S_DONE) && (!out_valid_q || out_ready);
		if (state_q == pat_pkg::S_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_q;
			tbl_wdata = '0;
		end else begin
			tbl_we    = (state_q == pat_pkg::S_LOOK) && !kind_q
				&& (look_status == pat_pkg::STAT_OK);
			tbl_waddr = addr_q;
			tbl_wdata = {1'b1, FW'(fidx_q)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pat_pkg::S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == pat_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath: the product frame * page_size is built by shift and add, one frame bit
	// per cycle, on top of base + offset.
	always_ff @(posedge clk) begin
		if (state_q == pat_pkg::S_IDLE && in_valid) begin
			kind_q <= kind;
			pidx_q <= page_index;
			fidx_q <= frame_index;
			addr_q <= TIW'(page_index);
		end
		if (state_q == pat_pkg::S_DIV && div_st.done) addr_q <= TIW'(quot);
		if (state_q == pat_pkg::S_LOOK) begin
			res_status_q <= look_status;
			acc_q        <= pat_pkg::PA_W'(base_address_q) + pat_pkg::PA_W'(rem);
			mcand_q      <= pat_pkg::PA_W'(ps_eff);
			mplier_q     <= rd_q[FW-1:0];
		end
		if (state_q == pat_pkg::S_MUL && mplier_q != '0) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[pat_pkg::PA_W-2:0], 1'b0};
			mplier_q <= mplier_q >> 1;
		end
		if (out_load) begin
			status_q <= res_status_q;
			physical_address_q <= (kind_q && res_status_q == pat_pkg::STAT_OK) ? acc_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) table_mem[tbl_waddr] <= tbl_wdata;
		rd_q <= table_mem[addr_q];
	end

	assign out_valid        = out_valid_q;
	assign physical_address = physical_address_q;
	assign status           = status_q;

endmodule
